// File: hdl/nearest_palette_color_search_assert.svh
// ----------------------------------------------------------------------------
// nearest palette color search assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define NPCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest_palette_color_search: check failed");

// consequent must hold in the cycle after the antecedent
`define NPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_palette_color_search: check failed");

`else

`define NPCS_ASSERT_SAME(lbl, ante, cons)
`define NPCS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types, constants and the microcode program of the palette search
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int INDEX_W = 8;
  localparam int COLOR_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = 21;
  localparam int CFG_W   = 9;
  localparam int TDATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

  // func codes carried in s_axis_tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_DISP  = 3'd1;
  localparam step_t ST_CHECK = 3'd2;
  localparam step_t ST_SCAN  = 3'd3;
  localparam step_t ST_DRAIN = 3'd4;
  localparam step_t ST_RES_Q = 3'd5;
  localparam step_t ST_WRITE = 3'd6;
  localparam step_t ST_EMPTY = 3'd7;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_NO_ITEM   = 3'd1,
    C_IS_WRITE  = 3'd2,
    C_IS_EMPTY  = 3'd3,
    C_SCAN_MORE = 3'd4,
    C_PIPE_BUSY = 3'd5
  } cond_e;

  typedef enum logic [1:0] {
    RK_WRITE = 2'd0,
    RK_EMPTY = 2'd1,
    RK_QUERY = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic      in_ready;
    logic      wait_out;
    logic      mem_wr;
    logic      cnt_load;
    logic      rd_issue;
    logic      best_clr;
    logic      out_load;
    res_kind_e out_kind;
    cond_e     cond;
    step_t     target;
  } ucode_t;

  // status seen by the sequencer
  typedef struct packed {
    logic item_valid;
    logic is_write;
    logic is_empty;
    logic cnt_nonzero;
    logic zero_found;
    logic pipe_busy;
    logic out_busy;
  } seq_stat_t;

  // strobes driven by the sequencer
  typedef struct packed {
    logic      in_ready;
    logic      mem_wr;
    logic      cnt_load;
    logic      rd_issue;
    logic      best_clr;
    logic      out_load;
    res_kind_e out_kind;
  } seq_ctl_t;

  // status of the distance datapath
  typedef struct packed {
    logic busy;
    logic zero_found;
    logic best_vld;
  } dist_stat_t;

  // control store: taken jump goes to target, otherwise next step
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '0;
    case (step)
      ST_IDLE: begin
        uc.in_ready = 1'b1;
        uc.cond     = C_NO_ITEM;
        uc.target   = ST_IDLE;
      end
      ST_DISP: begin
        uc.cond   = C_IS_WRITE;
        uc.target = ST_WRITE;
      end
      ST_CHECK: begin
        uc.cnt_load = 1'b1;
        uc.best_clr = 1'b1;
        uc.cond     = C_IS_EMPTY;
        uc.target   = ST_EMPTY;
      end
      ST_SCAN: begin
        uc.rd_issue = 1'b1;
        uc.cond     = C_SCAN_MORE;
        uc.target   = ST_SCAN;
      end
      ST_DRAIN: begin
        uc.cond   = C_PIPE_BUSY;
        uc.target = ST_DRAIN;
      end
      ST_RES_Q: begin
        uc.wait_out = 1'b1;
        uc.out_load = 1'b1;
        uc.out_kind = RK_QUERY;
        uc.cond     = C_ALWAYS;
        uc.target   = ST_IDLE;
      end
      ST_WRITE: begin
        uc.wait_out = 1'b1;
        uc.mem_wr   = 1'b1;
        uc.out_load = 1'b1;
        uc.out_kind = RK_WRITE;
        uc.cond     = C_ALWAYS;
        uc.target   = ST_IDLE;
      end
      ST_EMPTY: begin
        uc.wait_out = 1'b1;
        uc.out_load = 1'b1;
        uc.out_kind = RK_EMPTY;
        uc.cond     = C_ALWAYS;
        uc.target   = ST_IDLE;
      end
      default: begin
        uc.cond   = C_ALWAYS;
        uc.target = ST_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

// File: hdl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist
// weighted rgb distance pipeline with running best entry
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_dist
  import npcs_pkg::*;
#(
  parameter int AW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clr_i,
  input  wire logic               rd_vld_i,
  input  wire logic [AW-1:0]      rd_idx_i,
  input  wire logic [ENTRY_W-1:0] rdata_i,
  input  wire logic [COLOR_W-1:0] qry_red_i,
  input  wire logic [COLOR_W-1:0] qry_green_i,
  input  wire logic [COLOR_W-1:0] qry_blue_i,
  output logic      [AW-1:0]      best_idx_o,
  output logic      [DIST_W-1:0]  best_dist_o,
  output dist_stat_t              stat_o
);

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // stage 1: ram data lines up with the index read in the cycle before
  logic              s1_vld_q;
  logic [AW-1:0]     s1_idx_q;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r_d, sq_g_d, sq_b_d;

  // stage 2: squares registered
  logic              s2_vld_q;
  logic [AW-1:0]     s2_idx_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] dist_w;
  logic              upd;

  logic              best_vld_q;
  logic [AW-1:0]     best_idx_q;
  logic [DIST_W-1:0] best_dist_q;

  assign dr = abs_diff(qry_red_i,   rdata_i[3*COLOR_W-1:2*COLOR_W]);
  assign dg = abs_diff(qry_green_i, rdata_i[2*COLOR_W-1:COLOR_W]);
  assign db = abs_diff(qry_blue_i,  rdata_i[COLOR_W-1:0]);

  assign sq_r_d = SQ_W'(dr) * SQ_W'(dr);
  assign sq_g_d = SQ_W'(dg) * SQ_W'(dg);
  assign sq_b_d = SQ_W'(db) * SQ_W'(db);

  // 11*r + 16*g + 5*b as shifts and adds
  assign dist_w = (DIST_W'(sq_r_q) << 3) + (DIST_W'(sq_r_q) << 1) + DIST_W'(sq_r_q)
                + (DIST_W'(sq_g_q) << 4)
                + (DIST_W'(sq_b_q) << 2) + DIST_W'(sq_b_q);

  // strictly smaller wins, so on a tie the earlier (higher) index stays
  assign upd = s2_vld_q && (!best_vld_q || (dist_w < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_vld_i;
      s2_vld_q <= s1_vld_q;
      if (clr_i) begin
        best_vld_q <= 1'b0;
      end else if (upd) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_idx_i;
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= sq_r_d;
    sq_g_q   <= sq_g_d;
    sq_b_q   <= sq_b_d;
    if (upd) begin
      best_idx_q  <= s2_idx_q;
      best_dist_q <= dist_w;
    end
  end

  assign best_idx_o        = best_idx_q;
  assign best_dist_o       = best_dist_q;
  assign stat_o.busy       = s1_vld_q || s2_vld_q;
  assign stat_o.zero_found = best_vld_q && (best_dist_q == '0);
  assign stat_o.best_vld   = best_vld_q;

endmodule

`default_nettype wire

// File: hdl/npcs_seq.sv
// ----------------------------------------------------------------------------
// npcs_seq
// microcode sequencer: step counter, control store and conditional jumps
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_seq
  import npcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire seq_stat_t stat_i,
  output seq_ctl_t       ctl_o
);

  step_t  step_q, step_d;
  ucode_t uc;
  logic   stall;
  logic   take;

  assign uc    = ucode_rom(step_q);
  // result steps hold while the output register is still occupied
  assign stall = uc.wait_out && stat_i.out_busy;

  always_comb begin
    case (uc.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_ITEM:   take = !stat_i.item_valid;
      C_IS_WRITE:  take = stat_i.is_write;
      C_IS_EMPTY:  take = stat_i.is_empty;
      C_SCAN_MORE: take = stat_i.cnt_nonzero && !stat_i.zero_found;
      C_PIPE_BUSY: take = stat_i.pipe_busy;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (take) begin
      step_d = uc.target;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o.in_ready = uc.in_ready;
  assign ctl_o.mem_wr   = uc.mem_wr && !stall;
  assign ctl_o.cnt_load = uc.cnt_load;
  assign ctl_o.rd_issue = uc.rd_issue;
  assign ctl_o.best_clr = uc.best_clr;
  assign ctl_o.out_load = uc.out_load && !stall;
  assign ctl_o.out_kind = uc.out_kind;

endmodule

`default_nettype wire

// File: hdl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// palette store with weighted rgb nearest-color search
// ----------------------------------------------------------------------------
// Each input item either writes one palette entry (tuser 0) or searches the
// palette for the color closest to the item's rgb (tuser 1), and every item
// gives exactly one result item. A search walks entries palette_size-1 down
// to 0 with the weight 11*dr^2 + 16*dg^2 + 5*db^2 and keeps the strictly
// smaller distance, so a tie goes to the higher index; it stops as soon as
// an exact match is seen and reports exact_hit. The walk reads one entry per
// cycle from a single-port palette ram, and that read port sets the speed:
// a search is accepted, checked, walks its entries and drains the distance
// pipeline before its result is loaded (an exact match ends the walk early,
// reads in flight still drain); a write or an empty search skips the walk.
// A finished result sits in the output register, so the next item is taken
// while it waits. palette_size is saturated to PALETTE_DEPTH; writes to an
// index at or beyond PALETTE_DEPTH are dropped but still answered. Entries
// must be written before a search reaches them. Write palette_size only when
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_search_assert.svh"

module nearest_palette_color_search
  import npcs_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  // palette_size register
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,

  // input items
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,
  // func[0]
  input  wire logic               s_axis_tuser_i,

  // result items
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // best_index[7:0], exact_hit[8], best_distance[29:9], palette_empty[30]
  output logic      [TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AW   = $clog2(PALETTE_DEPTH);
  // wide enough for palette_size and for the depth itself
  localparam int SZ_W = ($clog2(PALETTE_DEPTH + 1) > CFG_W) ?
                        $clog2(PALETTE_DEPTH + 1) : CFG_W;

  // config
  logic [CFG_W-1:0]   cfg_size_q;

  // captured request
  logic               req_func_q;
  logic [INDEX_W-1:0] req_idx_q;
  logic [COLOR_W-1:0] req_red_q, req_green_q, req_blue_q;
  logic               in_acc;

  // scan counter, counts down from n-1
  logic [AW-1:0]      cnt_q;
  logic [SZ_W-1:0]    size_ext, size_sat;
  logic [AW-1:0]      cnt_init;

  // palette ram
  logic               idx_ok;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_rdata;

  // datapath
  logic [AW-1:0]      best_idx;
  logic [DIST_W-1:0]  best_dist;
  dist_stat_t         dstat;

  // sequencer
  seq_stat_t          sstat;
  seq_ctl_t           ctl;

  // output register
  logic               out_vld_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic               out_exact_q;
  logic [DIST_W-1:0]  out_dist_q;
  logic               out_empty_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      cfg_size_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------- request
  assign s_axis_tready_o = ctl.in_ready;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_func_q  <= s_axis_tuser_i;
      req_idx_q   <= s_axis_tdata_i[INDEX_W-1:0];
      req_red_q   <= s_axis_tdata_i[INDEX_W+COLOR_W-1:INDEX_W];
      req_green_q <= s_axis_tdata_i[INDEX_W+2*COLOR_W-1:INDEX_W+COLOR_W];
      req_blue_q  <= s_axis_tdata_i[INDEX_W+3*COLOR_W-1:INDEX_W+2*COLOR_W];
    end
  end

  // ---------------------------------------------------------- scan counter
  assign size_ext = SZ_W'(cfg_size_q);
  assign size_sat = (size_ext > SZ_W'(PALETTE_DEPTH)) ? SZ_W'(PALETTE_DEPTH) : size_ext;
  // only used when the palette is not empty
  assign cnt_init = AW'(size_sat - SZ_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl.cnt_load) begin
      cnt_q <= cnt_init;
    end else if (ctl.rd_issue && (cnt_q != '0)) begin
      cnt_q <= cnt_q - AW'(1);
    end
  end

  // ----------------------------------------------------------- palette ram
  assign idx_ok   = (SZ_W'(req_idx_q) < SZ_W'(PALETTE_DEPTH));
  assign mem_we   = ctl.mem_wr && idx_ok;
  assign mem_addr = ctl.mem_wr ? AW'(req_idx_q) : cnt_q;

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (ctl.rd_issue),
    .addr_i  (mem_addr),
    .wdata_i ({req_red_q, req_green_q, req_blue_q}),
    .rdata_o (mem_rdata)
  );

  // -------------------------------------------------------- distance path
  npcs_dist #(
    .AW (AW)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (ctl.best_clr),
    .rd_vld_i    (ctl.rd_issue),
    .rd_idx_i    (cnt_q),
    .rdata_i     (mem_rdata),
    .qry_red_i   (req_red_q),
    .qry_green_i (req_green_q),
    .qry_blue_i  (req_blue_q),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist),
    .stat_o      (dstat)
  );

  // ------------------------------------------------------------- sequencer
  assign sstat.item_valid  = s_axis_tvalid_i;
  assign sstat.is_write    = (req_func_q == FUNC_WRITE);
  assign sstat.is_empty    = (cfg_size_q == '0);
  assign sstat.cnt_nonzero = (cnt_q != '0);
  assign sstat.zero_found  = dstat.zero_found;
  assign sstat.pipe_busy   = dstat.busy;
  assign sstat.out_busy    = out_vld_q && !m_axis_tready_i;

  npcs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (sstat),
    .ctl_o  (ctl)
  );

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      case (ctl.out_kind)
        RK_QUERY: begin
          out_idx_q   <= INDEX_W'(best_idx);
          out_exact_q <= (best_dist == '0);
          out_dist_q  <= best_dist;
          out_empty_q <= 1'b0;
        end
        RK_EMPTY: begin
          out_idx_q   <= '0;
          out_exact_q <= 1'b0;
          out_dist_q  <= '0;
          out_empty_q <= 1'b1;
        end
        default: begin
          out_idx_q   <= '0;
          out_exact_q <= 1'b0;
          out_dist_q  <= '0;
          out_empty_q <= 1'b0;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_empty_q, out_dist_q, out_exact_q, out_idx_q};

  // ------------------------------------------------------------ assertions
  // a new item is only taken once the scan pipeline has drained
  `NPCS_ASSERT_SAME(a_ready_pipe_idle, s_axis_tready_o, !dstat.busy)
  // palette writes never collide with a scan read on the single port
  `NPCS_ASSERT_SAME(a_no_wr_during_rd, mem_we, !ctl.rd_issue)
  // a search result is only loaded after at least one entry was compared
  `NPCS_ASSERT_SAME(a_query_has_best, ctl.out_load && (ctl.out_kind == RK_QUERY),
                    dstat.best_vld && !dstat.busy)
  // a loaded result shows up as a valid output item in the next cycle
  `NPCS_ASSERT_NEXT(a_load_shows, ctl.out_load, m_axis_tvalid_o)

endmodule

`default_nettype wire
